/* hw/rtl/ndp_pkg.sv */
// shared constants, types and helpers of the dual prior parameter block
package ndp_pkg;

  // value format
  localparam int VW      = 48;
  localparam int FB      = 24;
  localparam int PREC_W  = 64;
  localparam int BETA_W  = VW - 1;

  // gamma threshold, raw value of 1e10
  localparam longint unsigned GAMMA_INT = 64'd10000000000;
  localparam logic [PREC_W-1:0] GAMMA_RAW = PREC_W'(GAMMA_INT) << FB;

  // working widths
  localparam int G_W   = 34 + FB;        // gamma below the threshold
  localparam int W_W   = VW + 4;         // front sums of z and beta
  localparam int P_W   = VW + 1;         // magnitudes p and q
  localparam int S_W   = P_W + 1;        // p + q
  localparam int D_W   = P_W + 1;        // factor of the beta*gamma term
  localparam int MA_W  = G_W + S_W;      // multiplier operand a
  localparam int MB_W  = S_W;            // multiplier operand b
  localparam int PR_W  = MA_W + MB_W;    // product
  localparam int NUM_W = PR_W - 1;       // numerator magnitude
  localparam int DEN_W = MA_W;           // denominator
  localparam int QB    = VW;             // quotient bits

  // pipeline depths
  localparam int MUL_DIG = 10;
  localparam int MUL_LAT = (MB_W + MUL_DIG - 1) / MUL_DIG;
  localparam int DIV_LAT = QB + 2;
  localparam int BACK_LAT = 2 * MUL_LAT + 1 + DIV_LAT;

  // configuration
  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [IDX_W-1:0] REG_CONSTRAINED = 3'd1;
  localparam logic [IDX_W-1:0] REG_WEIGHT      = 3'd2;
  localparam logic [IDX_W-1:0] REG_LOWER       = 3'd3;
  localparam logic [IDX_W-1:0] REG_UPPER       = 3'd4;

  localparam logic [2:0] MODE_ABS   = 3'd0;
  localparam logic [2:0] MODE_LOWER = 3'd1;
  localparam logic [2:0] MODE_UPPER = 3'd2;
  localparam logic [2:0] MODE_BOX   = 3'd3;

  // classified request: mean = (2c*p*q + sign*b*g*d) / (g*s), var = 2pq / (g*s)
  typedef struct packed {
    logic [P_W-1:0]       p;
    logic [P_W-1:0]       q;
    logic [S_W-1:0]       s;
    logic [BETA_W-1:0]    b;
    logic [G_W-1:0]       g;
    logic [D_W-1:0]       d;
    logic                 d_neg;
    logic signed [VW-1:0] c;
  } item_t;

  // magnitude of a front sum
  function automatic logic [W_W-1:0] abs_w(input logic signed [W_W-1:0] x);
    logic [W_W-1:0] r;
    r = x[W_W-1] ? W_W'(-x) : W_W'(x);
    return r;
  endfunction

  // one partial product of the digit multiplier
  function automatic logic [PR_W-1:0] mul_digit(input logic [MA_W-1:0] a,
                                                input logic [MUL_DIG-1:0] dg,
                                                input int unsigned sh);
    logic [PR_W-1:0] ae;
    logic [PR_W-1:0] de;
    ae = PR_W'(a);
    de = PR_W'(dg);
    return (ae * de) << sh;
  endfunction

endpackage

/* hw/rtl/ndp_if.sv */
// request, result and configuration channels
interface ndp_in_if;
  logic                         valid;
  logic                         ready;
  logic [ndp_pkg::PREC_W-1:0]   precision;
  logic signed [ndp_pkg::VW-1:0] dual_value;
  modport source (output valid, precision, dual_value, input ready);
  modport sink (input valid, precision, dual_value, output ready);
endinterface

interface ndp_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [ndp_pkg::VW-1:0] prec_mean;
  logic signed [ndp_pkg::VW-1:0] prec_var;
  logic                          fault;
  modport source (output valid, prec_mean, prec_var, fault, input ready);
  modport sink (input valid, prec_mean, prec_var, fault, output ready);
endinterface

interface ndp_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [ndp_pkg::IDX_W-1:0]   index;
  logic [ndp_pkg::VW-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/ndp_mul.sv */
// digit-serial pipelined multiplier, one digit of b per stage
module ndp_mul (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [ndp_pkg::MA_W-1:0]   a_i,
  input  logic [ndp_pkg::MB_W-1:0]   b_i,
  output logic [ndp_pkg::PR_W-1:0]   p_o
);
  localparam int BP_W = ndp_pkg::MUL_LAT * ndp_pkg::MUL_DIG;

  logic [ndp_pkg::PR_W-1:0] acc_q [ndp_pkg::MUL_LAT];
  logic [ndp_pkg::MA_W-1:0] a_q   [ndp_pkg::MUL_LAT];
  logic [BP_W-1:0]          b_q   [ndp_pkg::MUL_LAT];
  logic [BP_W-1:0]          b_pad;

  assign b_pad = BP_W'(b_i);

  // first digit
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q[0] <= ndp_pkg::mul_digit(a_i, b_pad[ndp_pkg::MUL_DIG-1:0], 0);
      a_q[0]   <= a_i;
      b_q[0]   <= b_pad;
    end
  end

  // remaining digits, accumulated stage by stage
  for (genvar s = 1; s < ndp_pkg::MUL_LAT; s++) begin : g_dig
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[s] <= acc_q[s-1] + ndp_pkg::mul_digit(a_q[s-1],
                    b_q[s-1][s*ndp_pkg::MUL_DIG +: ndp_pkg::MUL_DIG], s * ndp_pkg::MUL_DIG);
        a_q[s]   <= a_q[s-1];
        b_q[s]   <= b_q[s-1];
      end
    end
  end

  assign p_o = acc_q[ndp_pkg::MUL_LAT-1];
endmodule

/* hw/rtl/ndp_div.sv */
// pipelined restoring divider with rounding, saturation and sign
module ndp_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic                        neg_i,
  input  logic [ndp_pkg::NUM_W-1:0]   num_i,
  input  logic [ndp_pkg::DEN_W-1:0]   den_i,
  output logic signed [ndp_pkg::VW-1:0] val_o,
  output logic                        fault_o
);
  localparam int NW = ndp_pkg::NUM_W;
  localparam int DW = ndp_pkg::DEN_W;
  localparam int QB = ndp_pkg::QB;
  localparam logic [QB:0] HALF = (QB+1)'(1) << (QB - 1);

  typedef struct packed {
    logic neg;
    logic ovf;
    logic dz;
    logic nz;
  } flags_t;

  logic [NW-1:0] r_q  [QB+1];
  logic [DW-1:0] d_q  [QB+1];
  logic [QB-1:0] qt_q [QB+1];
  flags_t        fl_q [QB+1];

  // entry: overflow, zero checks
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]      <= num_i;
      d_q[0]      <= den_i;
      qt_q[0]     <= '0;
      fl_q[0].neg <= neg_i;
      fl_q[0].ovf <= {1'b0, num_i} >= ((NW+1)'(den_i) << QB);
      fl_q[0].dz  <= den_i == '0;
      fl_q[0].nz  <= num_i != '0;
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= QB; k++) begin : g_step
    localparam int J = QB - k;
    logic [NW:0] trial;
    logic        ge;
    assign trial = (NW+1)'(d_q[k-1]) << J;
    assign ge    = {1'b0, r_q[k-1]} >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]  <= ge ? r_q[k-1] - trial[NW-1:0] : r_q[k-1];
        d_q[k]  <= d_q[k-1];
        qt_q[k] <= qt_q[k-1] | (ge ? (QB'(1) << J) : '0);
        fl_q[k] <= fl_q[k-1];
      end
    end
  end

  // rounding and saturation
  logic          rnd;
  logic [QB:0]   qr;
  logic [QB:0]   lim;
  logic          sat;
  logic [QB-1:0] mag;
  logic [QB-1:0] val_d;
  logic          fault_d;
  flags_t        fl;

  always_comb begin
    fl  = fl_q[QB];
    rnd = {r_q[QB][DW-1:0], 1'b0} >= {1'b0, d_q[QB]};
    qr  = {1'b0, qt_q[QB]} + (QB+1)'(rnd);
    lim = fl.neg ? HALF : HALF - (QB+1)'(1);
    sat = fl.ovf || (qr > lim);
    mag = sat ? lim[QB-1:0] : qr[QB-1:0];
    if (fl.dz) begin
      val_d   = fl.nz ? lim[QB-1:0] : '0;
      fault_d = 1'b1;
    end else begin
      val_d   = fl.neg ? QB'(-mag) : mag;
      fault_d = sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_o   <= $signed(val_d);
      fault_o <= fault_d;
    end
  end
endmodule

/* hw/rtl/ndp_queue.sv */
// two-entry queue between front and back
module ndp_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ndp_pkg::item_t       item_i,
  output logic                 ready_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output ndp_pkg::item_t       item_o
);
  ndp_pkg::item_t ent_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;
  logic           do_push, do_pop;

  assign ready_o = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign item_o  = ent_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) ent_q[wr_q] <= item_i;
  end
endmodule

/* hw/rtl/ndp_front.sv */
// configuration registers and classification of each request
module ndp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  ndp_in_if.sink          in_i,
  ndp_cfg_if.sink         cfg_i,
  output logic            push_o,
  output ndp_pkg::item_t  item_o,
  input  logic            ready_i
);
  localparam int VW = ndp_pkg::VW;
  localparam int WW = ndp_pkg::W_W;
  localparam int PW = ndp_pkg::P_W;

  logic [2:0]                    mode_q;
  logic                          hard_q;
  logic [ndp_pkg::BETA_W-1:0]    beta_q;
  logic signed [VW-1:0]          lower_q, upper_q;

  // configuration writes
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ndp_pkg::MODE_ABS;
      hard_q  <= 1'b0;
      beta_q  <= ndp_pkg::BETA_W'(1) << ndp_pkg::FB;
      lower_q <= '0;
      upper_q <= VW'(1) << ndp_pkg::FB;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        ndp_pkg::REG_MODE:        mode_q  <= cfg_i.data[2:0];
        ndp_pkg::REG_CONSTRAINED: hard_q  <= cfg_i.data[0];
        ndp_pkg::REG_WEIGHT:      beta_q  <= cfg_i.data[ndp_pkg::BETA_W-1:0];
        ndp_pkg::REG_LOWER:       lower_q <= $signed(cfg_i.data);
        ndp_pkg::REG_UPPER:       upper_q <= $signed(cfg_i.data);
        default: ;
      endcase
    end
  end

  assign in_i.ready = ready_i;
  assign push_o     = in_i.valid;

  // magnitudes of z shifted by beta
  logic signed [WW-1:0] zw, bw;
  logic [WW-1:0]        az, azpb, azmb, azp2b, azm2b;
  logic [PW-1:0]        pz, ppb, pmb, pp2b, pm2b;
  logic signed [PW:0]   qmp;
  logic                 big, z_le0;

  always_comb begin
    zw    = {{(WW-VW){in_i.dual_value[VW-1]}}, in_i.dual_value};
    bw    = $signed(WW'(beta_q));
    az    = ndp_pkg::abs_w(zw);
    azpb  = ndp_pkg::abs_w(zw + bw);
    azmb  = ndp_pkg::abs_w(zw - bw);
    azp2b = ndp_pkg::abs_w(zw + (bw <<< 1));
    azm2b = ndp_pkg::abs_w(zw - (bw <<< 1));
    pz    = az[PW-1:0];
    ppb   = azpb[PW-1:0];
    pmb   = azmb[PW-1:0];
    pp2b  = azp2b[PW-1:0];
    pm2b  = azm2b[PW-1:0];
    qmp   = $signed({1'b0, pmb}) - $signed({1'b0, ppb});
    big   = in_i.precision > ndp_pkg::GAMMA_RAW;
    z_le0 = in_i.dual_value[VW-1] || (in_i.dual_value == '0);
  end

  // formula selection
  always_comb begin
    item_o       = '0;
    item_o.s     = ndp_pkg::S_W'(1);
    item_o.g     = in_i.precision[ndp_pkg::G_W-1:0];
    item_o.b     = beta_q;
    if (big) begin
      // negated dual value
      item_o.b     = ndp_pkg::BETA_W'(1);
      item_o.g     = ndp_pkg::G_W'(1);
      item_o.d     = ndp_pkg::D_W'(pz);
      item_o.d_neg = ~in_i.dual_value[VW-1];
    end else if (hard_q && (mode_q == ndp_pkg::MODE_LOWER || mode_q == ndp_pkg::MODE_UPPER ||
                            mode_q == ndp_pkg::MODE_BOX)) begin
      // hard constraint: (2c +/- g)|z| / g
      item_o.p     = pz;
      item_o.q     = PW'(1);
      item_o.b     = ndp_pkg::BETA_W'(1);
      item_o.d     = ndp_pkg::D_W'(pz);
      if (mode_q == ndp_pkg::MODE_LOWER || (mode_q == ndp_pkg::MODE_BOX && z_le0)) begin
        item_o.c     = lower_q;
        item_o.d_neg = 1'b0;
      end else begin
        item_o.c     = upper_q;
        item_o.d_neg = 1'b1;
      end
    end else begin
      unique case (mode_q)
        ndp_pkg::MODE_ABS: begin
          item_o.p     = ppb;
          item_o.q     = pmb;
          item_o.c     = lower_q;
          item_o.d_neg = qmp[PW];
          item_o.d     = qmp[PW] ? ndp_pkg::D_W'(-qmp) : ndp_pkg::D_W'(qmp);
        end
        ndp_pkg::MODE_LOWER: begin
          item_o.p     = ppb;
          item_o.q     = pz;
          item_o.c     = lower_q;
          item_o.d     = ndp_pkg::D_W'(pz);
        end
        ndp_pkg::MODE_UPPER: begin
          item_o.p     = pz;
          item_o.q     = pmb;
          item_o.c     = upper_q;
          item_o.d     = ndp_pkg::D_W'(pz);
          item_o.d_neg = 1'b1;
        end
        ndp_pkg::MODE_BOX: begin
          item_o.q     = pz;
          item_o.d     = {pz, 1'b0};
          if (z_le0) begin
            item_o.p     = pp2b;
            item_o.c     = lower_q;
          end else begin
            item_o.p     = pm2b;
            item_o.c     = upper_q;
            item_o.d_neg = 1'b1;
          end
        end
        default: begin
          // quadratic: beta*a / 2^FB and beta, over a denominator of 2^(FB+1)
          item_o.p     = PW'(beta_q);
          item_o.q     = PW'(1);
          item_o.c     = lower_q;
          item_o.b     = '0;
          item_o.g     = ndp_pkg::G_W'(1) << (ndp_pkg::FB + 1);
        end
      endcase
      if (mode_q == ndp_pkg::MODE_ABS || mode_q == ndp_pkg::MODE_LOWER ||
          mode_q == ndp_pkg::MODE_UPPER || mode_q == ndp_pkg::MODE_BOX) begin
        item_o.s = ndp_pkg::S_W'(item_o.p) + ndp_pkg::S_W'(item_o.q);
      end
    end
  end
endmodule

/* hw/rtl/ndp_back.sv */
// products, numerators and the two quotients, one request per cycle unless the result is held
module ndp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  ndp_pkg::item_t  item_i,
  output logic            pop_o,
  ndp_out_if.source       out_o
);
  localparam int ML = ndp_pkg::MUL_LAT;
  localparam int NW = ndp_pkg::NUM_W;
  localparam int VW = ndp_pkg::VW;

  typedef struct packed {
    logic signed [VW-1:0]      c;
    logic [ndp_pkg::D_W-1:0]   d;
    logic                      d_neg;
  } side1_t;

  typedef struct packed {
    logic                        c_neg;
    logic                        d_neg;
    logic [ndp_pkg::MA_W-1:0]    pq;
    logic [ndp_pkg::DEN_W-1:0]   den;
  } side2_t;

  logic                         en;
  logic [ndp_pkg::BACK_LAT-1:0] vld_q;

  // whole pipeline moves unless the result register is held
  assign en    = !vld_q[ndp_pkg::BACK_LAT-1] || out_o.ready;
  assign pop_o = en && valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[ndp_pkg::BACK_LAT-2:0], valid_i};
    end
  end

  // first product layer: p*q, beta*g, g*s
  logic [ndp_pkg::PR_W-1:0] pq_p, bg_p, den_p;
  ndp_mul u_mul_pq (.clk_i, .en_i(en), .a_i(ndp_pkg::MA_W'(item_i.p)),
                    .b_i(ndp_pkg::MB_W'(item_i.q)), .p_o(pq_p));
  ndp_mul u_mul_bg (.clk_i, .en_i(en), .a_i(ndp_pkg::MA_W'(item_i.g)),
                    .b_i(ndp_pkg::MB_W'(item_i.b)), .p_o(bg_p));
  ndp_mul u_mul_den (.clk_i, .en_i(en), .a_i(ndp_pkg::MA_W'(item_i.g)),
                     .b_i(ndp_pkg::MB_W'(item_i.s)), .p_o(den_p));

  side1_t sd1_q [ML];
  always_ff @(posedge clk_i) begin
    if (en) begin
      sd1_q[0] <= '{c: item_i.c, d: item_i.d, d_neg: item_i.d_neg};
      for (int i = 1; i < ML; i++) sd1_q[i] <= sd1_q[i-1];
    end
  end

  // second product layer: |c|*pq and beta*g*d
  logic [VW-1:0]            c_mag;
  logic [ndp_pkg::PR_W-1:0] cpq_p, e_p;
  assign c_mag = sd1_q[ML-1].c[VW-1] ? VW'(-sd1_q[ML-1].c) : VW'(sd1_q[ML-1].c);

  ndp_mul u_mul_cpq (.clk_i, .en_i(en), .a_i(pq_p[ndp_pkg::MA_W-1:0]),
                     .b_i(ndp_pkg::MB_W'(c_mag)), .p_o(cpq_p));
  ndp_mul u_mul_e (.clk_i, .en_i(en), .a_i(bg_p[ndp_pkg::MA_W-1:0]),
                   .b_i(ndp_pkg::MB_W'(sd1_q[ML-1].d)), .p_o(e_p));

  side2_t sd2_q [ML];
  always_ff @(posedge clk_i) begin
    if (en) begin
      sd2_q[0] <= '{c_neg: sd1_q[ML-1].c[VW-1], d_neg: sd1_q[ML-1].d_neg,
                    pq: pq_p[ndp_pkg::MA_W-1:0], den: den_p[ndp_pkg::DEN_W-1:0]};
      for (int i = 1; i < ML; i++) sd2_q[i] <= sd2_q[i-1];
    end
  end

  // signed numerator of the mean, numerator of the precision
  logic signed [NW:0]          n1, n2, nsum;
  logic [NW-1:0]               nm_d;
  logic                        nneg_d;
  logic [NW-1:0]               nm_q, nv_q;
  logic                        nneg_q;
  logic [ndp_pkg::DEN_W-1:0]   den_q;

  always_comb begin
    n1     = $signed({1'b0, cpq_p[NW-2:0], 1'b0});
    n2     = $signed({1'b0, e_p[NW-1:0]});
    nsum   = (sd2_q[ML-1].c_neg ? -n1 : n1) + (sd2_q[ML-1].d_neg ? -n2 : n2);
    nneg_d = nsum[NW];
    nm_d   = nneg_d ? NW'(-nsum) : NW'(nsum);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nm_q   <= nm_d;
      nneg_q <= nneg_d;
      nv_q   <= NW'(sd2_q[ML-1].pq) << (ndp_pkg::FB + 1);
      den_q  <= sd2_q[ML-1].den;
    end
  end

  // quotients; their final registers hold the result
  logic fault_m, fault_v;

  ndp_div u_div_mean (.clk_i, .en_i(en), .neg_i(nneg_q), .num_i(nm_q), .den_i(den_q),
                      .val_o(out_o.prec_mean), .fault_o(fault_m));
  ndp_div u_div_var (.clk_i, .en_i(en), .neg_i(1'b0), .num_i(nv_q), .den_i(den_q),
                     .val_o(out_o.prec_var), .fault_o(fault_v));

  assign out_o.fault = fault_m | fault_v;
  assign out_o.valid = vld_q[ndp_pkg::BACK_LAT-1];
endmodule

/* hw/rtl/nup_dual_prior_parameters.sv */
// top level of the dual prior parameter block
//
//  channel  dir  payload                          handshake
//  in_i     in   precision, dual_value            valid / ready
//  cfg_i    in   index, data                      valid / ready, always ready
//  out_o    out  prec_mean, prec_var, fault       valid / ready
//
// one request per cycle sustained while out_o is ready; most of the delay from a request
// to its result lies in the 48-step quotient pipelines
// the front queue holds two requests, so the input side keeps moving until it is full
// while the result register is held; a held result freezes the whole back pipeline
// asynchronous active-low reset clears the configuration to its defaults and
// empties the queue and pipeline
module nup_dual_prior_parameters (
  input  logic        clk_i,
  input  logic        rst_ni,
  ndp_in_if.sink      in_i,
  ndp_cfg_if.sink     cfg_i,
  ndp_out_if.source   out_o
);
  logic           push, q_ready, q_valid, pop;
  ndp_pkg::item_t push_item, pop_item;

  // request classification
  ndp_front u_front (
    .clk_i, .rst_ni, .in_i, .cfg_i,
    .push_o(push), .item_o(push_item), .ready_i(q_ready)
  );

  // decoupling queue
  ndp_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .item_i(push_item), .ready_o(q_ready),
    .pop_i(pop), .valid_o(q_valid), .item_o(pop_item)
  );

  // arithmetic
  ndp_back u_back (
    .clk_i, .rst_ni,
    .valid_i(q_valid), .item_i(pop_item), .pop_o(pop), .out_o
  );
endmodule

/* sim/nup_dual_prior_parameters_tb.sv */
// testbench of the dual prior parameter block: random requests checked against a predictor
`timescale 1ns / 100ps

module nup_dual_prior_parameters_tb;
  localparam int VW     = ndp_pkg::VW;
  localparam int FB     = ndp_pkg::FB;
  localparam int PREC_W = ndp_pkg::PREC_W;
  localparam int BETA_W = ndp_pkg::BETA_W;
  localparam int IDX_W  = ndp_pkg::IDX_W;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 80;
  localparam int N_PHASES = 24;
  localparam int ITEMS_PER_PHASE = 70;

  typedef logic [255:0] wide_t;

  // sign and magnitude value for exact arithmetic
  typedef struct {
    logic  neg;
    wide_t m;
  } smag_t;

  typedef struct {
    logic [PREC_W-1:0]    precision;
    logic signed [VW-1:0] dual_value;
  } req_t;

  typedef struct {
    logic [VW-1:0] prec_mean;
    logic [VW-1:0] prec_var;
    logic          fault;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ndp_in_if  in_if ();
  ndp_cfg_if cfg_if ();
  ndp_out_if out_if ();

  nup_dual_prior_parameters u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .cfg_i  (cfg_if.sink),
    .out_o  (out_if.source)
  );

  always #2 clk_i = ~clk_i;

  // shadow of the configuration registers
  logic [2:0]        prior_mode = 3'd0;
  logic              hard_mode = 1'b0;
  logic [BETA_W-1:0] beta_reg = BETA_W'(1) << FB;
  logic [VW-1:0]     lower_reg = '0;
  logic [VW-1:0]     upper_reg = VW'(1) << FB;

  req_t  pend_q[$];
  res_t  expected_q[$];
  int    fail_count = 0;
  int    idle_cycles = 0;
  logic  gaps_on = 1'b1;
  int    send_gap = 0;
  int    stall_cnt = 0;

  // exact arithmetic helpers
  function automatic smag_t mk(input logic n, input wide_t m);
    smag_t r;
    r.m = m;
    r.neg = n && (m != 0);
    return r;
  endfunction

  function automatic smag_t from_raw(input logic [VW-1:0] v);
    logic [VW-1:0] nv;
    nv = -v;
    return v[VW-1] ? mk(1'b1, wide_t'(nv)) : mk(1'b0, wide_t'(v));
  endfunction

  function automatic smag_t s_add(input smag_t a, input smag_t b);
    if (a.neg == b.neg) return mk(a.neg, a.m + b.m);
    if (a.m >= b.m) return mk(a.neg, a.m - b.m);
    return mk(b.neg, b.m - a.m);
  endfunction

  function automatic smag_t s_neg(input smag_t a);
    return mk(!a.neg, a.m);
  endfunction

  function automatic smag_t s_mul(input smag_t a, input smag_t b);
    return mk(a.neg ^ b.neg, a.m * b.m);
  endfunction

  function automatic smag_t s_abs(input smag_t a);
    return mk(1'b0, a.m);
  endfunction

  function automatic smag_t s_shl(input smag_t a, input int n);
    return mk(a.neg, a.m << n);
  endfunction

  // rounded, saturated quotient
  function automatic logic [VW-1:0] quotient(input smag_t num, input wide_t den,
                                              inout logic flt);
    wide_t half, lim, q, r;
    half = wide_t'(1) << (VW - 1);
    lim = num.neg ? half : half - 1;
    if (den == 0) begin
      flt = 1'b1;
      if (num.m == 0) return '0;
      return VW'(lim);
    end
    q = num.m / den;
    r = num.m % den;
    if ((r << 1) >= den) q = q + 1;
    if (q > lim) begin
      flt = 1'b1;
      q = lim;
    end
    return num.neg ? VW'(-q) : VW'(q);
  endfunction

  function automatic void hard_terms(input smag_t c, input logic plus_g, input smag_t g,
                                     input smag_t z, inout res_t r);
    smag_t az, coef;
    az = s_abs(z);
    coef = plus_g ? s_add(s_shl(c, 1), g) : s_add(s_shl(c, 1), s_neg(g));
    r.prec_mean = quotient(s_mul(coef, az), g.m, r.fault);
    r.prec_var = quotient(s_shl(az, 1 + FB), g.m, r.fault);
  endfunction

  function automatic void free_terms(input smag_t p, input smag_t q, input smag_t c,
                                     input smag_t extra, input smag_t g, inout res_t r);
    smag_t pq;
    wide_t den;
    pq = s_mul(p, q);
    den = g.m * (p.m + q.m);
    r.prec_mean = quotient(s_add(s_shl(s_mul(c, pq), 1), extra), den, r.fault);
    r.prec_var = quotient(s_shl(pq, 1 + FB), den, r.fault);
  endfunction

  // expected precision-mean and precision of one request
  function automatic res_t prior_params(input req_t rq);
    res_t r;
    smag_t g, z, beta, two_beta, a, b, bg, p, q;
    r = '{default: '0};
    g = mk(1'b0, wide_t'(rq.precision));
    z = from_raw(rq.dual_value);
    beta = mk(1'b0, wide_t'(beta_reg));
    two_beta = s_shl(beta, 1);
    a = from_raw(lower_reg);
    b = from_raw(upper_reg);
    bg = s_mul(beta, g);
    if (rq.precision > ndp_pkg::GAMMA_RAW) begin
      r.prec_mean = quotient(s_neg(z), wide_t'(1), r.fault);
    end else if (prior_mode == ndp_pkg::MODE_ABS) begin
      p = s_abs(s_add(z, beta));
      q = s_abs(s_add(z, s_neg(beta)));
      free_terms(p, q, a, s_mul(bg, s_add(q, s_neg(p))), g, r);
    end else if (prior_mode == ndp_pkg::MODE_LOWER) begin
      if (hard_mode) hard_terms(a, 1'b1, g, z, r);
      else free_terms(s_abs(s_add(z, beta)), s_abs(z), a, s_mul(bg, s_abs(z)), g, r);
    end else if (prior_mode == ndp_pkg::MODE_UPPER) begin
      if (hard_mode) hard_terms(b, 1'b0, g, z, r);
      else free_terms(s_abs(z), s_abs(s_add(z, s_neg(beta))), b,
                      s_neg(s_mul(bg, s_abs(z))), g, r);
    end else if (prior_mode == ndp_pkg::MODE_BOX) begin
      q = s_abs(z);
      if (z.neg || z.m == 0) begin
        if (hard_mode) hard_terms(a, 1'b1, g, z, r);
        else free_terms(s_abs(s_add(z, two_beta)), q, a, s_shl(s_mul(bg, q), 1), g, r);
      end else begin
        if (hard_mode) hard_terms(b, 1'b0, g, z, r);
        else free_terms(s_abs(s_add(z, s_neg(two_beta))), q, b,
                        s_neg(s_shl(s_mul(bg, q), 1)), g, r);
      end
    end else begin
      r.prec_mean = quotient(s_mul(beta, a), wide_t'(1) << FB, r.fault);
      r.prec_var = quotient(beta, wide_t'(1), r.fault);
    end
    return r;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.precision <= '0;
      in_if.dual_value <= '0;
      send_gap <= 0;
    end else begin
      if (in_if.valid && in_if.ready)
        expected_q.push_back(prior_params('{in_if.precision, in_if.dual_value}));
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_if.valid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          req_t rq;
          rq = pend_q.pop_front();
          in_if.precision <= rq.precision;
          in_if.dual_value <= rq.dual_value;
          in_if.valid <= 1'b1;
          send_gap <= gaps_on ? $urandom_range(0, 10) : 0;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_cnt <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        int nxt;
        int errs;
        res_t ex;
        nxt = gaps_on ? $urandom_range(0, 10) : 0;
        errs = 0;
        stall_cnt <= nxt;
        out_if.ready <= (nxt == 0);
        if (expected_q.size() == 0) begin
          $error("result with no request waiting");
          errs = errs + 1;
        end else begin
          ex = expected_q.pop_front();
          if (out_if.prec_mean !== ex.prec_mean) begin
            $error("prec_mean expected %h actual %h", ex.prec_mean, out_if.prec_mean);
            errs = errs + 1;
          end
          if (out_if.prec_var !== ex.prec_var) begin
            $error("prec_var expected %h actual %h", ex.prec_var, out_if.prec_var);
            errs = errs + 1;
          end
          if (out_if.fault !== ex.fault) begin
            $error("fault expected %b actual %b", ex.fault, out_if.fault);
            errs = errs + 1;
          end
        end
        fail_count <= fail_count + errs;
      end else if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic drain();
    while (pend_q.size() > 0 || in_if.valid || expected_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [VW-1:0] data);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    case (idx)
      ndp_pkg::REG_MODE:        prior_mode = data[2:0];
      ndp_pkg::REG_CONSTRAINED: hard_mode = data[0];
      ndp_pkg::REG_WEIGHT:      beta_reg = data[BETA_W-1:0];
      ndp_pkg::REG_LOWER:       lower_reg = data;
      ndp_pkg::REG_UPPER:       upper_reg = data;
      default: ;
    endcase
  endtask

  function automatic logic [VW-1:0] pick_value(input int sel);
    case (sel)
      0: return {1'b0, {(VW-1){1'b1}}};
      1: return {1'b1, {(VW-1){1'b0}}};
      2: return '0;
      3: return VW'(1) << FB;
      4: return -(VW'(3) << (FB - 1));
      5: return VW'($urandom_range(0, 255)) << ($urandom_range(0, 30));
      6: return -(VW'($urandom_range(0, 255)) << ($urandom_range(0, 30)));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [PREC_W-1:0] rand_gamma();
    case ($urandom_range(0, 7))
      0: return {$urandom, $urandom};
      1: return ndp_pkg::GAMMA_RAW + PREC_W'($urandom_range(0, 2)) - 1;
      2: return '0;
      3: return PREC_W'($urandom_range(1, 8));
      4: return PREC_W'({$urandom, $urandom}) >> $urandom_range(6, 63);
      default: return PREC_W'($urandom_range(1, 1 << 16)) << ($urandom_range(8, 30));
    endcase
  endfunction

  function automatic logic [VW-1:0] rand_dual();
    logic [VW-1:0] bv;
    bv = VW'(beta_reg);
    case ($urandom_range(0, 7))
      0: return pick_value($urandom_range(0, 7));
      1: return bv + VW'($urandom_range(0, 2)) - 1;
      2: return -bv + VW'($urandom_range(0, 2)) - 1;
      3: return (bv << 1) + VW'($urandom_range(0, 2)) - 1;
      4: return -(bv << 1) + VW'($urandom_range(0, 2)) - 1;
      5: return VW'($urandom_range(0, 4)) - 2;
      default: return VW'({$urandom, $urandom}) >>> $urandom_range(0, 30);
    endcase
  endfunction

  initial begin
    req_t rq;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        reg_write(ndp_pkg::REG_MODE, VW'(ph % 8));
        reg_write(ndp_pkg::REG_CONSTRAINED, VW'((ph / 8) % 2));
        reg_write(ndp_pkg::REG_WEIGHT, (ph % 5 == 0) ? VW'(0) :
                  (ph % 5 == 1) ? VW'({(BETA_W){1'b1}}) : VW'(pick_value(5)));
        reg_write(ndp_pkg::REG_LOWER, pick_value((ph + 1) % 8));
        reg_write(ndp_pkg::REG_UPPER, pick_value((ph * 3) % 8));
      end
      gaps_on = (ph % 4 != 3);

      // directed corners: gamma zero, threshold, extremes of z, z at plus and minus beta
      if (ph < 16) begin
        pend_q.push_back('{PREC_W'(0), VW'(VW'(1) << FB)});
        pend_q.push_back('{PREC_W'(0), VW'(0)});
        pend_q.push_back('{ndp_pkg::GAMMA_RAW, VW'(-(VW'(1) << FB))});
        pend_q.push_back('{ndp_pkg::GAMMA_RAW + 1, {1'b1, {(VW-1){1'b0}}}});
        pend_q.push_back('{{PREC_W{1'b1}}, {1'b0, {(VW-1){1'b1}}}});
        pend_q.push_back('{PREC_W'(1) << FB, {1'b0, {(VW-1){1'b1}}}});
        pend_q.push_back('{PREC_W'(1) << FB, {1'b1, {(VW-1){1'b0}}}});
        pend_q.push_back('{PREC_W'(1), VW'(beta_reg)});
        pend_q.push_back('{PREC_W'(1) << FB, -VW'(beta_reg)});
        pend_q.push_back('{ndp_pkg::GAMMA_RAW, VW'(beta_reg) << 1});
      end

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        rq.precision = rand_gamma();
        rq.dual_value = rand_dual();
        pend_q.push_back(rq);
      end
    end

    drain();
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
